@@ hw/rtl/sws_pkg.sv @@
// Shared types and constants for the sliding-window sum, mean, minimum and maximum block.
`default_nettype none

package sws_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int VALUE_W        = 42;
   localparam int WLEN_W         = 11;
   localparam int MODE_W         = 2;
   localparam int CSR_IDX_W      = 1;
   localparam int WINDOW_MAX_DEF = 1024;
   localparam int SUM_W_DEF      = 42;

   typedef enum logic [MODE_W-1:0] {
      MODE_SUM  = 2'd0,
      MODE_MEAN = 2'd1,
      MODE_MIN  = 2'd2,
      MODE_MAX  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LEN = 1'b0,
      CSR_MODE       = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       restart;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      valid_res;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/sws_div.sv @@
// Serial restoring divider: signed dividend by unsigned divisor, quotient truncated toward zero.
`default_nettype none

module sws_div #(
   parameter int NUM_W = sws_pkg::SUM_W_DEF,
   parameter int DEN_W = sws_pkg::WLEN_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] numer,
   input  logic        [DEN_W-1:0] denom,
   output logic                    done,
   output logic signed [NUM_W-1:0] quot
);

   import sws_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic             neg_ff, neg_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = denom;
         neg_in  = numer[NUM_W-1];
         quo_in  = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
      end else if (busy_ff) begin
         // One quotient bit per cycle, most significant first.
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

`default_nettype wire

@@ hw/rtl/sliding_window_sum_mean_min_max.sv @@
// Top level of the sliding-window sum, mean, minimum and maximum block.
//
// Each sample beat accepted on the req_ channel yields exactly one result beat on the rsp_
// channel: the sum, the mean truncated toward zero, the minimum or the maximum of the last
// window_len samples of the current series, as chosen by the mode register. Until window_len
// samples of a series have been seen the result value is zero and valid_res is low. A beat with
// restart set opens a new series, and so does any write to window_len or mode; a written window
// length of zero acts as one and one above WINDOW_MAX is clamped to WINDOW_MAX. Registers may only
// be written while the block holds no sample in progress. The block works on one sample at a
// time under a small sequencer and takes a new sample only when the previous one has finished,
// though the finished result may still wait in the output register. An accepted sample goes
// through a ring read while the sample is added to the sum, the removal of the leaving sample,
// the expiry check of the deque front, the comparisons at the back of the deque (a read and a
// compare for each entry popped) and the push. Minimum and maximum mode then read the front,
// and mean mode waits for the one-bit-per-cycle divider. The block is ready for the next
// sample on the cycle after the result has moved to the output register. The sample ring and
// the deque are single-ported memories whose contents are only ever used at entries written in
// the current series, so no clearing pass is needed after reset.
`default_nettype none

module sliding_window_sum_mean_min_max #(
   parameter int WINDOW_MAX = sws_pkg::WINDOW_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sws_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sws_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [sws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sws_pkg::WLEN_W-1:0]     csr_wdata
);

   import sws_pkg::*;

   // Address width of the ring and the deque, width of the position counter (which wraps at
   // twice WINDOW_MAX), width of the deque fill count and width of the exact running sum.
   localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int POS_MOD = 2 * WINDOW_MAX;
   localparam int PW      = $clog2(POS_MOD);
   localparam int CW      = $clog2(WINDOW_MAX + 1);
   localparam int IW      = CW + 1;
   localparam int AGW     = PW + 1;
   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_MAX);
   localparam int EW      = SAMPLE_W + PW;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_RING_RD  = 11'b000_0000_0010,
      ST_SUM      = 11'b000_0000_0100,
      ST_EXPIRE   = 11'b000_0000_1000,
      ST_BACK_RD  = 11'b000_0001_0000,
      ST_BACK_CMP = 11'b000_0010_0000,
      ST_PUSH     = 11'b000_0100_0000,
      ST_HEAD_RD  = 11'b000_1000_0000,
      ST_HEAD_VAL = 11'b001_0000_0000,
      ST_DIV      = 11'b010_0000_0000,
      ST_OUT      = 11'b100_0000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic [WLEN_W-1:0]         window_len_ff, window_len_in;
   mode_type                  mode_ff, mode_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [AW-1:0]             tail_ff, tail_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [WLEN_W-1:0]         seen_ff, seen_in;
   logic [PW-1:0]             pos_ff, pos_in;
   logic [AW-1:0]             wp_ff, wp_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   logic                      res_valid_ff, res_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   // Sample ring and deque storage with registered read data.
   logic [SAMPLE_W-1:0]       ring_ff [WINDOW_MAX];
   logic [EW-1:0]             deque_ff [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] ring_rdata_ff;
   logic [EW-1:0]             dq_rdata_ff;
   logic                      ring_re, ring_we;
   logic                      dq_re, dq_we;
   logic [AW-1:0]             ring_ra;
   logic [AW-1:0]             dq_ra;

   logic                      div_start;
   logic                      div_done;
   logic signed [SUM_W-1:0]   div_quot;

   logic [WLEN_W-1:0]         wlen_wr;
   logic [CW-1:0]             w_c;
   logic [IW-1:0]             wp_x, w_x, old_full;
   logic [AGW-1:0]            pos_x, dpos_x, age;
   logic                      expired;
   logic signed [SAMPLE_W-1:0] dq_val_c;
   logic                      dominated;
   logic                      seen_full;
   logic                      valid_c;
   logic [AW-1:0]             head_inc, tail_inc, tail_dec, wp_inc;
   logic [PW-1:0]             pos_inc;

   // Clamp a written window length into one to WINDOW_MAX.
   always_comb begin
      if (csr_wdata == '0) begin
         wlen_wr = WLEN_W'(1);
      end else if (int'(csr_wdata) > WINDOW_MAX) begin
         wlen_wr = WLEN_W'(WINDOW_MAX);
      end else begin
         wlen_wr = csr_wdata;
      end
   end

   always_comb begin
      window_len_in = window_len_ff;
      mode_in       = mode_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_LEN: window_len_in = wlen_wr;
            CSR_MODE:       mode_in       = mode_type'(csr_wdata[MODE_W-1:0]);
            default:        ;
         endcase
      end
   end

   // Index and age arithmetic. Both the ring index and the position wrap at counts that need
   // not be powers of two, so each difference is one compare and one subtract.
   always_comb begin
      w_c      = CW'(window_len_ff);
      wp_x     = IW'(wp_ff);
      w_x      = IW'(w_c);
      old_full = (wp_x >= w_x) ? (wp_x - w_x) : (wp_x + IW'(WINDOW_MAX) - w_x);
      ring_ra  = old_full[AW-1:0];

      pos_x    = AGW'(pos_ff);
      dpos_x   = AGW'(dq_rdata_ff[PW-1:0]);
      age      = (pos_x >= dpos_x) ? (pos_x - dpos_x) : (pos_x + AGW'(POS_MOD) - dpos_x);
      expired  = (age >= AGW'(w_c));

      dq_val_c  = dq_rdata_ff[EW-1:PW];
      // Ties go against the older entry, so equality pops it.
      dominated = (mode_ff == MODE_MAX) ? (dq_val_c <= x_ff) : (dq_val_c >= x_ff);

      seen_full = (seen_ff >= window_len_ff);
      valid_c   = ((WLEN_W+1)'(seen_ff) + (WLEN_W+1)'(1)) >= (WLEN_W+1)'(window_len_ff);

      head_inc = (head_ff == AW'(WINDOW_MAX - 1)) ? '0 : head_ff + AW'(1);
      tail_inc = (tail_ff == AW'(WINDOW_MAX - 1)) ? '0 : tail_ff + AW'(1);
      tail_dec = (tail_ff == '0) ? AW'(WINDOW_MAX - 1) : tail_ff - AW'(1);
      wp_inc   = (wp_ff == AW'(WINDOW_MAX - 1)) ? '0 : wp_ff + AW'(1);
      pos_inc  = (pos_ff == PW'(POS_MOD - 1)) ? '0 : pos_ff + PW'(1);
   end

   // Sequencer. Each state does at most one access to each memory.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      sum_in       = sum_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      wp_in        = wp_ff;
      res_value_in = res_value_ff;
      res_valid_in = res_valid_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      ring_re      = 1'b0;
      ring_we      = 1'b0;
      dq_re        = 1'b0;
      dq_we        = 1'b0;
      dq_ra        = head_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in = req_data.sample;
               if (req_data.restart) begin
                  sum_in  = '0;
                  head_in = '0;
                  tail_in = '0;
                  cnt_in  = '0;
                  seen_in = '0;
                  pos_in  = '0;
                  wp_in   = '0;
               end
               state_in = ST_RING_RD;
            end
         end
         ST_RING_RD: begin
            // Fetch the sample leaving the window while the new one is added in.
            ring_re  = 1'b1;
            sum_in   = sum_ff + SUM_W'(x_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (seen_full) begin
               sum_in = sum_ff - SUM_W'(ring_rdata_ff);
            end
            ring_we  = 1'b1;
            dq_re    = 1'b1;
            dq_ra    = head_ff;
            state_in = ST_EXPIRE;
         end
         ST_EXPIRE: begin
            if ((cnt_ff != '0) && expired) begin
               head_in = head_inc;
               cnt_in  = cnt_ff - CW'(1);
            end
            state_in = ST_BACK_RD;
         end
         ST_BACK_RD: begin
            if (cnt_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               dq_re    = 1'b1;
               dq_ra    = tail_dec;
               state_in = ST_BACK_CMP;
            end
         end
         ST_BACK_CMP: begin
            if (dominated) begin
               tail_in  = tail_dec;
               cnt_in   = cnt_ff - CW'(1);
               state_in = ST_BACK_RD;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            dq_we        = 1'b1;
            tail_in      = tail_inc;
            cnt_in       = cnt_ff + CW'(1);
            seen_in      = seen_full ? seen_ff : seen_ff + WLEN_W'(1);
            pos_in       = pos_inc;
            wp_in        = wp_inc;
            res_valid_in = valid_c;
            res_value_in = '0;
            state_in     = ST_OUT;
            if (valid_c) begin
               case (mode_ff) inside
                  MODE_SUM: begin
                     res_value_in = VALUE_W'(sum_ff);
                  end
                  MODE_MEAN: begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
                  MODE_MIN, MODE_MAX: begin
                     state_in = ST_HEAD_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_HEAD_RD: begin
            dq_re    = 1'b1;
            dq_ra    = head_ff;
            state_in = ST_HEAD_VAL;
         end
         ST_HEAD_VAL: begin
            res_value_in = VALUE_W'(dq_val_c);
            state_in     = ST_OUT;
         end
         ST_DIV: begin
            if (div_done) begin
               res_value_in = VALUE_W'(div_quot);
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.value     = res_value_ff;
               rsp_in.valid_res = res_valid_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write opens a new series.
      if (csr_we) begin
         sum_in  = '0;
         head_in = '0;
         tail_in = '0;
         cnt_in  = '0;
         seen_in = '0;
         pos_in  = '0;
         wp_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= WLEN_W'(1);
         mode_ff       <= MODE_SUM;
         sum_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         cnt_ff        <= '0;
         seen_ff       <= '0;
         pos_ff        <= '0;
         wp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         mode_ff       <= mode_in;
         sum_ff        <= sum_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
         seen_ff       <= seen_in;
         pos_ff        <= pos_in;
         wp_ff         <= wp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      res_value_ff <= res_value_in;
      res_valid_ff <= res_valid_in;
      rsp_ff       <= rsp_in;
   end

   // Sample ring: the sample leaving the window is read before the new one is written.
   always_ff @(posedge clock) begin
      if (ring_re) begin
         ring_rdata_ff <= ring_ff[ring_ra];
      end
      if (ring_we) begin
         ring_ff[wp_ff] <= x_ff;
      end
   end

   // Deque of value and position pairs.
   always_ff @(posedge clock) begin
      if (dq_re) begin
         dq_rdata_ff <= deque_ff[dq_ra];
      end
      if (dq_we) begin
         deque_ff[tail_ff] <= {x_ff, pos_ff};
      end
   end

   sws_div #(
      .NUM_W (SUM_W),
      .DEN_W (WLEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (sum_ff),
      .denom (window_len_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(window_len_ff))
      else $error("deque holds more entries than the window");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= window_len_ff)
      else $error("seen count ran past the window length");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.valid_res) |-> (rsp_ff.value == '0))
      else $error("result beat without a full window carries a non-zero value");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new sample taken while one is still in progress");

   a_div_mean_only: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (mode_ff == MODE_MEAN))
      else $error("divider started outside mean mode");

endmodule

`default_nettype wire

@@ sim/sws_window_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the sliding-window block: mirrors the window arithmetic and compares beats.
module sws_window_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  sws_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  sws_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [sws_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sws_pkg::WLEN_W-1:0]    csr_wdata,
   output int unsigned                   mismatches,
   output int unsigned                   windows_pending
);

   import sws_pkg::*;

   localparam int WMAX      = WINDOW_MAX_DEF;
   localparam int IDX_W     = $clog2(WMAX);
   localparam int POS_W     = IDX_W + 1;
   localparam int EXP_DEPTH = 8;

   logic [WLEN_W-1:0]          win_len;
   mode_type                   win_mode;
   logic signed [SAMPLE_W-1:0] history [WMAX];
   logic signed [VALUE_W-1:0]  window_total;
   logic signed [SAMPLE_W-1:0] dq_value [WMAX];
   logic [POS_W-1:0]           dq_pos [WMAX];
   logic [IDX_W-1:0]           dq_head;
   logic [IDX_W-1:0]           dq_tail;
   logic [POS_W-1:0]           dq_fill;
   logic [WLEN_W-1:0]          seen;
   logic [POS_W-1:0]           sample_pos;

   // Predicted result beats in order, held in a small ring between acceptance and delivery.
   rsp_type                    expected_windows [EXP_DEPTH];
   int unsigned                exp_wr = 0;
   int unsigned                exp_rd = 0;

   task automatic clear_history();
      window_total = '0;
      dq_head      = '0;
      dq_tail      = '0;
      dq_fill      = '0;
      seen         = '0;
      sample_pos   = '0;
   endtask

   task automatic apply_write(input logic [CSR_IDX_W-1:0] idx, input logic [WLEN_W-1:0] data);
      case (idx)
         CSR_WINDOW_LEN: begin
            if (data == 0)
               win_len = 1;
            else if (data > WMAX)
               win_len = WMAX;
            else
               win_len = data;
         end
         CSR_MODE: begin
            win_mode = mode_type'(data[MODE_W-1:0]);
         end
         default: ;
      endcase
      clear_history();
   endtask

   // Takes one sample into the ring, the running total and the deque, and works out its window.
   task automatic advance_window(input req_type beat, output rsp_type outcome);
      logic signed [SAMPLE_W-1:0] x;
      logic [IDX_W-1:0]           old_slot;
      logic [IDX_W-1:0]           back;
      logic [POS_W-1:0]           age;
      logic                       take_max;
      logic                       full;
      x        = beat.sample;
      take_max = (win_mode == MODE_MAX);
      if (beat.restart)
         clear_history();

      window_total = window_total + x;
      if (seen >= win_len) begin
         old_slot     = sample_pos[IDX_W-1:0] - win_len[IDX_W-1:0];
         window_total = window_total - history[old_slot];
      end
      history[sample_pos[IDX_W-1:0]] = x;

      // The front entry leaves once it has fallen out of the window.
      if (dq_fill != 0) begin
         age = sample_pos - dq_pos[dq_head];
         if (age >= win_len) begin
            dq_head = dq_head + 1'b1;
            dq_fill = dq_fill - 1'b1;
         end
      end
      // Older entries lose ties, so equal values are popped as well.
      while (dq_fill != 0) begin
         back = dq_tail - 1'b1;
         if (take_max ? (dq_value[back] <= x) : (dq_value[back] >= x)) begin
            dq_tail = back;
            dq_fill = dq_fill - 1'b1;
         end else begin
            break;
         end
      end
      dq_value[dq_tail] = x;
      dq_pos[dq_tail]   = sample_pos;
      dq_tail           = dq_tail + 1'b1;
      dq_fill           = dq_fill + 1'b1;

      full = (seen + 1 >= win_len);
      if (seen < win_len)
         seen = seen + 1'b1;
      sample_pos = sample_pos + 1'b1;

      outcome.valid_res = full;
      outcome.value     = '0;
      if (full) begin
         case (win_mode)
            MODE_SUM:  outcome.value = window_total;
            MODE_MEAN: outcome.value = window_total / $signed({1'b0, win_len});
            default:   outcome.value = dq_value[dq_head];
         endcase
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      if (reset) begin
         win_len  = 1;
         win_mode = MODE_SUM;
         clear_history();
         exp_wr     = 0;
         exp_rd     = 0;
         mismatches = 0;
      end else begin
         if (csr_we)
            apply_write(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            advance_window(req_data, want);
            if (exp_wr - exp_rd >= EXP_DEPTH) begin
               $error("more than %0d results outstanding", EXP_DEPTH);
               mismatches++;
            end else begin
               expected_windows[exp_wr % EXP_DEPTH] = want;
               exp_wr++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (exp_wr == exp_rd) begin
               $error("result beat with nothing expected: value %0d, valid_res %0b",
                      got.value, got.valid_res);
               mismatches++;
            end else begin
               want = expected_windows[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (got.value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, got.value);
                  mismatches++;
               end
               if (got.valid_res !== want.valid_res) begin
                  $error("valid_res: expected %0b, got %0b", want.valid_res, got.valid_res);
                  mismatches++;
               end
            end
         end
      end
      windows_pending = exp_wr - exp_rd;
   end

endmodule

@@ sim/sliding_window_sum_mean_min_max_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sliding-window block: clock, reset, stimulus, result sink and verdict.
module sliding_window_sum_mean_min_max_tb;
   import sws_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WLEN_W-1:0]    csr_wdata;
   int unsigned          mismatches;
   int unsigned          windows_pending;

   // Beat counts on each side; the sender compares them to know when the block has drained.
   int unsigned samples_sent = 0;
   int unsigned results_seen = 0;

   // Percentage chance of an idle burst before each sample beat.
   int unsigned gap_pct = 0;

   // Controls shared with the result sink. The long hold is asked for once and the sink
   // remembers that it has served it; the quiet tail switches off all idling in the sink.
   logic        long_hold_due  = 1'b0;
   logic        long_hold_done = 1'b0;
   logic        quiet_tail     = 1'b0;
   int unsigned sink_left      = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sliding_window_sum_mean_min_max dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sws_window_checker u_window_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .windows_pending (windows_pending)
   );

   // Result sink. Ready alternates at random between high stretches and stalls. When the long
   // hold is asked for, ready is held low in one long stretch while the sender keeps offering,
   // so that the block holds a finished result, stops taking samples and backs up.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         results_seen <= results_seen + 1;
      if (long_hold_due && !long_hold_done) begin
         long_hold_done <= 1'b1;
         rsp_ready      <= 1'b0;
         sink_left      <= 400;
      end else if (sink_left != 0) begin
         sink_left <= sink_left - 1;
      end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
         rsp_ready <= 1'b1;
         sink_left <= quiet_tail ? 0 : $urandom_range(0, 40);
      end else begin
         rsp_ready <= 1'b0;
         sink_left <= $urandom_range(0, 14);
      end
   end

   // Full-range values and, in equal share, small values so that equal samples meet
   // in the deque, and a sprinkling of the extremes of the sample range.
   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6, 7: return int'($urandom_range(0, 16)) - 8;
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return -1;
               3:       return 0;
               default: return 1;
            endcase
         end
      endcase
   endfunction

   // Offers one sample beat, perhaps after an idle burst, and returns at the edge that takes
   // it. Valid is left high so that a following beat goes out back to back; it is only
   // lowered for an idle burst or when a phase ends.
   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] value, input logic fresh);
      req_type beat;
      beat.sample  = value;
      beat.restart = fresh;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic run_series(input int unsigned count, input int unsigned restart_pct);
      repeat (count) offer_sample(draw_sample(), $urandom_range(0, 99) < restart_pct);
   endtask

   // Waits for every outstanding result, lets the block settle, then writes both registers.
   // The upper bits of the mode write carry noise, which the block must ignore.
   task automatic reconfigure(input logic [WLEN_W-1:0] wlen, input mode_type m);
      req_valid <= 1'b0;
      while (results_seen != samples_sent) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW_LEN;
      csr_wdata <= wlen;
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_wdata <= {(WLEN_W-MODE_W)'($urandom_range(0, 511)), m};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      mode_type pick;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_WINDOW_LEN;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings give a one-sample sum, so each result is the sample itself.
      offer_sample(32'sh7FFF_FFFF, 1'b0);
      offer_sample(32'sh8000_0000, 1'b0);
      offer_sample(-1, 1'b0);
      offer_sample(0, 1'b1);

      // A window length of zero behaves as a window of one.
      reconfigure('0, MODE_MAX);
      offer_sample(5, 1'b0);
      offer_sample(-5, 1'b0);

      // An oversized window length is clamped to the maximum, so this sample stays invalid;
      // the next register write then opens a new series part way through this one.
      reconfigure('1, MODE_MEAN);
      offer_sample(32'sh7FFF_FFFF, 1'b0);

      // Mean of the most negative samples, then a negative total that must truncate
      // toward zero rather than round down.
      reconfigure(3, MODE_MEAN);
      offer_sample(32'sh8000_0000, 1'b0);
      offer_sample(32'sh8000_0000, 1'b0);
      offer_sample(32'sh8000_0000, 1'b0);
      offer_sample(-7, 1'b0);
      offer_sample(0, 1'b0);
      offer_sample(0, 1'b0);

      // Minimum with equal samples in the deque, and a restart in the middle of a series.
      reconfigure(3, MODE_MIN);
      offer_sample(4, 1'b0);
      offer_sample(4, 1'b0);
      offer_sample(4, 1'b0);
      offer_sample(2, 1'b0);
      offer_sample(9, 1'b1);
      offer_sample(1, 1'b0);
      offer_sample(1, 1'b0);
      offer_sample(1, 1'b0);

      // Largest two-sample sum.
      reconfigure(2, MODE_SUM);
      offer_sample(32'sh7FFF_FFFF, 1'b0);
      offer_sample(32'sh7FFF_FFFF, 1'b0);

      // Long window in minimum mode with a rising ramp: nothing is ever popped from the back,
      // so the deque fills to the window length and its front expires as the window slides.
      // The random tail then brings lower values that pop entries from its back. The long receiver
      // hold falls at the start of this phase.
      reconfigure(500, MODE_MIN);
      long_hold_due <= 1'b1;
      gap_pct = 10;
      for (int i = 0; i < 506; i++)
         offer_sample(32'sh8000_0000 + i * 4_000_000, 1'b0);
      run_series(20, 0);

      // One longer series with a short window, so that the window slides many times.
      pick = mode_type'($urandom_range(0, 3));
      if (pick == MODE_MEAN)
         pick = MODE_MAX;
      reconfigure(WLEN_W'($urandom_range(2, 12)), pick);
      gap_pct = 20;
      run_series(150, 0);

      // Short phases with random settings and occasional restarts.
      for (int p = 0; p < 8; p++) begin
         logic [WLEN_W-1:0] wl;
         case ($urandom_range(0, 4))
            0:       wl = '0;
            1:       wl = 1;
            2:       wl = 2;
            3:       wl = WLEN_W'($urandom_range(3, 9));
            default: wl = WLEN_W'($urandom_range(10, 40));
         endcase
         reconfigure(wl, mode_type'($urandom_range(0, 3)));
         gap_pct = $urandom_range(0, 40);
         run_series(30, 5);
      end

      // Closing stretch at full rate on both sides.
      reconfigure(WLEN_W'($urandom_range(1, 20)), mode_type'($urandom_range(0, 3)));
      quiet_tail <= 1'b1;
      gap_pct = 0;
      run_series(60, 5);

      req_valid <= 1'b0;
      while (results_seen != samples_sent) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && windows_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         if (windows_pending != 0)
            $error("%0d expected results never arrived", windows_pending);
         $display("TEST FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest correct run.
   initial begin : watchdog
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sliding_window_sum_mean_min_max.f @@
hw/rtl/sws_pkg.sv
hw/rtl/sws_div.sv
hw/rtl/sliding_window_sum_mean_min_max.sv
sim/sws_window_checker.sv
sim/sliding_window_sum_mean_min_max_tb.sv
